/* sv/bcc_pkg.sv */
// shared types, register indexes and arithmetic helpers for the compensation core
package bcc_pkg;

	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 64;

	typedef enum logic [CfgIdxW-1:0] {
		REG_TEMP_CALIB = 2'd0,
		REG_PRESS_LOW  = 2'd1,
		REG_PRESS_MID  = 2'd2,
		REG_PRESS_LAST = 2'd3
	} reg_idx_t;

	// calibration words, all widened to 32-bit patterns
	typedef struct packed {
		logic [31:0] t1;
		logic [31:0] t2;
		logic [31:0] t3;
		logic [31:0] p1;
		logic [31:0] p2;
		logic [31:0] p3;
		logic [31:0] p4;
		logic [31:0] p5;
		logic [31:0] p6;
		logic [31:0] p7;
		logic [31:0] p8;
		logic [31:0] p9;
	} calib_t;

	// one result item
	typedef struct packed {
		logic        pressure_invalid;
		logic [31:0] pressure_pa;
		logic [31:0] temperature_centi;
		logic [31:0] fine_temperature;
	} result_t;

	localparam logic [31:0] PressOffset = 32'd64000;
	localparam logic [31:0] FullScale   = 32'd1048576;
	localparam logic [31:0] PressScale  = 32'd3125;
	localparam logic [31:0] SignBit     = 32'h8000_0000;
	localparam logic [31:0] DivBias     = 32'd32768;
	localparam logic [31:0] RoundHalf   = 32'd128;

	// 32-bit wrapping product
	function automatic logic [31:0] mul32(input logic [31:0] x, input logic [31:0] y);
		logic [63:0] full;
		full = x * y;
		return full[31:0];
	endfunction

	// arithmetic right shift of a 32-bit pattern, kept apart from unsigned sums
	function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
		return $signed(x) >>> n;
	endfunction

	function automatic logic [31:0] sext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

/* sv/bcc_divider.sv */
// pipelined restoring unsigned 32 by 32 divider, one quotient bit a stage
module bcc_divider #(
	parameter int unsigned TagW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [31:0]     dividend,
	input  logic [31:0]     divisor,
	input  logic [TagW-1:0] in_tag,
	output logic            out_valid,
	output logic [31:0]     quotient,
	output logic [TagW-1:0] out_tag
);
	import bcc_pkg::*;

	localparam int unsigned Steps = 32;

	logic [Steps:0]     vld_q;
	logic [31:0]        rem_q [Steps+1];
	logic [31:0]        quo_q [Steps+1];
	logic [31:0]        dvs_q [Steps+1];
	logic [TagW-1:0]    tag_q [Steps+1];

	assign vld_q[0] = in_valid;
	assign rem_q[0] = '0;
	assign quo_q[0] = dividend;
	assign dvs_q[0] = divisor;
	assign tag_q[0] = in_tag;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[Steps:1] <= '0;
		end else if (en) begin
			vld_q[Steps:1] <= vld_q[Steps-1:0];
		end
	end

	// one shift-subtract step per stage
	for (genvar i = 0; i < Steps; i++) begin : g_step
		logic [32:0] trial;
		logic [32:0] part;
		assign part  = {rem_q[i], quo_q[i][31]};
		assign trial = part - {1'b0, dvs_q[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (!trial[32]) begin
					rem_q[i+1] <= trial[31:0];
				end else begin
					rem_q[i+1] <= part[31:0];
				end
				quo_q[i+1] <= {quo_q[i][30:0], ~trial[32]};
				dvs_q[i+1] <= dvs_q[i];
				tag_q[i+1] <= tag_q[i];
			end
		end
	end

	assign out_valid = vld_q[Steps];
	assign quotient  = quo_q[Steps];
	assign out_tag   = tag_q[Steps];

endmodule

/* sv/bcc_front.sv */
// temperature compensation and pressure divisor/numerator stages
module bcc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [19:0]          temp_sample,
	input  logic [19:0]          press_sample,
	input  bcc_pkg::calib_t      cal,
	output logic                 out_valid,
	output logic [31:0]          fine_out,
	output logic [31:0]          centi_out,
	output logic [31:0]          num_out,
	output logic [31:0]          div_out,
	output logic                 shifted_out
);
	import bcc_pkg::*;

	logic [6:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[5:0], in_valid};
		end
	end

	// s1: temperature differences and first products
	logic [31:0] adct, dt;
	logic [31:0] ta_s1, dd_s1, adcp_s1;
	assign adct = {12'd0, temp_sample};
	assign dt   = (adct >> 4) - cal.t1;
	always_ff @(posedge clk) begin
		if (en) begin
			ta_s1   <= mul32((adct >> 3) - (cal.t1 << 1), cal.t2);
			dd_s1   <= mul32(dt, dt);
			adcp_s1 <= {12'd0, press_sample};
		end
	end

	// s2: t3 product
	logic [31:0] ta_s2, tb_s2, adcp_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			ta_s2   <= $signed(ta_s1) >>> 11;
			tb_s2   <= mul32($signed(dd_s1) >>> 12, cal.t3);
			adcp_s2 <= adcp_s1;
		end
	end

	// s3: fine temperature
	logic [31:0] fine_s3, adcp_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			fine_s3 <= ta_s2 + asr32(tb_s2, 14);
			adcp_s3 <= adcp_s2;
		end
	end

	// s4: centidegrees, pressure var1 and its quarter squared
	logic [31:0] a1, d1;
	logic [31:0] fine_s4, centi_s4, a_s4, dd_s4, adcp_s4;
	assign a1 = asr32(fine_s3, 1) - PressOffset;
	assign d1 = $signed(a1) >>> 2;
	always_ff @(posedge clk) begin
		if (en) begin
			fine_s4  <= fine_s3;
			centi_s4 <= $signed(mul32(fine_s3, 32'd5) + RoundHalf) >>> 8;
			a_s4     <= a1;
			dd_s4    <= mul32(d1, d1);
			adcp_s4  <= adcp_s3;
		end
	end

	// s5: calibration products
	logic [31:0] fine_s5, centi_s5, b6_s5, b5_s5, c3_s5, c2_s5, adcp_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			fine_s5  <= fine_s4;
			centi_s5 <= centi_s4;
			b6_s5    <= mul32($signed(dd_s4) >>> 11, cal.p6);
			b5_s5    <= mul32(a_s4, cal.p5);
			c3_s5    <= mul32(cal.p3, $signed(dd_s4) >>> 13);
			c2_s5    <= mul32(cal.p2, a_s4);
			adcp_s5  <= adcp_s4;
		end
	end

	// s6: var2 and the divisor sum
	logic [31:0] bsum, csum;
	logic [31:0] fine_s6, centi_s6, b_s6, c_s6, adcp_s6;
	assign bsum = b6_s5 + (b5_s5 << 1);
	assign csum = ($signed(c3_s5) >>> 3) + ($signed(c2_s5) >>> 1);
	always_ff @(posedge clk) begin
		if (en) begin
			fine_s6  <= fine_s5;
			centi_s6 <= centi_s5;
			b_s6     <= asr32(bsum, 2) + (cal.p4 << 16);
			c_s6     <= DivBias + asr32(csum, 18);
			adcp_s6  <= adcp_s5;
		end
	end

	// s7: divisor and numerator products
	logic [31:0] fine_s7, centi_s7, dv_s7, pn_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			fine_s7  <= fine_s6;
			centi_s7 <= centi_s6;
			dv_s7    <= $signed(mul32(c_s6, cal.p1)) >>> 15;
			pn_s7    <= mul32((FullScale - adcp_s6) - asr32(b_s6, 12), PressScale);
		end
	end

	assign out_valid   = vld_q[6];
	assign fine_out    = fine_s7;
	assign centi_out   = centi_s7;
	assign div_out     = dv_s7;
	assign shifted_out = (pn_s7 < SignBit);
	assign num_out     = (pn_s7 < SignBit) ? (pn_s7 << 1) : pn_s7;

endmodule

/* sv/bcc_back.sv */
// final pressure correction stages after the division
module bcc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [31:0]      quotient,
	input  logic             shifted,
	input  logic             zero_div,
	input  logic [31:0]      fine_in,
	input  logic [31:0]      centi_in,
	input  bcc_pkg::calib_t  cal,
	output logic             out_valid,
	output bcc_pkg::result_t result
);
	import bcc_pkg::*;

	logic [2:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[1:0], in_valid};
		end
	end

	// s1: pressure before correction and its squared eighth
	logic [31:0] pq, p8;
	logic [31:0] p_s1, sq_s1, fine_s1, centi_s1;
	logic        z_s1;
	assign pq = shifted ? quotient : (quotient << 1);
	assign p8 = pq >> 3;
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1     <= pq;
			sq_s1    <= mul32(p8, p8) >> 13;
			z_s1     <= zero_div;
			fine_s1  <= fine_in;
			centi_s1 <= centi_in;
		end
	end

	// s2: p9 and p8 products
	logic [31:0] p_s2, a_s2, b_s2, fine_s2, centi_s2;
	logic        z_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2     <= p_s1;
			a_s2     <= mul32(cal.p9, sq_s1);
			b_s2     <= mul32(p_s1 >> 2, cal.p8);
			z_s2     <= z_s1;
			fine_s2  <= fine_s1;
			centi_s2 <= centi_s1;
		end
	end

	// s3: correction sum and zero divisor guard
	logic [31:0] corr;
	assign corr = asr32(a_s2, 12) + asr32(b_s2, 13) + cal.p7;
	always_ff @(posedge clk) begin
		if (en) begin
			result.fine_temperature  <= fine_s2;
			result.temperature_centi <= centi_s2;
			result.pressure_pa       <= z_s2 ? '0 : p_s2 + asr32(corr, 4);
			result.pressure_invalid  <= z_s2;
		end
	end

	assign out_valid = vld_q[2];

endmodule

/* sv/barometric_compensation_core.sv */
// top level of the barometric compensation core
//  channel  | dir | contents
//  s_axis   | in  | tdata: temp sample[19:0], press sample[39:20]
//  m_axis   | out | tdata: fine[31:0], centi[63:32], pressure_pa[95:64], invalid[96]
//  cfg      | in  | cfg_we, cfg_index, cfg_data
// one request per cycle while the output is not stalled; each passes the front, divider and back stages in order.
// the whole pipeline advances when the output slot is empty or taken.
// stalls freeze every stage; nothing is dropped or repeated.
// reset clears valid bits and calibration registers.
module barometric_compensation_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [39:0]                   s_axis_tdata, // temp sample, press sample
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [103:0]                  m_axis_tdata, // fine, centi, pressure_pa, invalid
	input  logic                          cfg_we,
	input  logic [bcc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [bcc_pkg::CfgDataW-1:0]  cfg_data
);
	import bcc_pkg::*;

	logic [47:0] tcal_q;
	logic [63:0] plow_q, pmid_q;
	logic [15:0] plast_q;
	calib_t      cal;

	// calibration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcal_q  <= '0;
			plow_q  <= '0;
			pmid_q  <= '0;
			plast_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TEMP_CALIB: tcal_q  <= cfg_data[47:0];
				REG_PRESS_LOW:  plow_q  <= cfg_data;
				REG_PRESS_MID:  pmid_q  <= cfg_data;
				REG_PRESS_LAST: plast_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// unpack calibration words
	always_comb begin
		cal.t1 = {16'd0, tcal_q[15:0]};
		cal.t2 = sext16(tcal_q[31:16]);
		cal.t3 = sext16(tcal_q[47:32]);
		cal.p1 = {16'd0, plow_q[15:0]};
		cal.p2 = sext16(plow_q[31:16]);
		cal.p3 = sext16(plow_q[47:32]);
		cal.p4 = sext16(plow_q[63:48]);
		cal.p5 = sext16(pmid_q[15:0]);
		cal.p6 = sext16(pmid_q[31:16]);
		cal.p7 = sext16(pmid_q[47:32]);
		cal.p8 = sext16(pmid_q[63:48]);
		cal.p9 = sext16(plast_q);
	end

	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	logic        f_vld, f_shifted;
	logic [31:0] f_fine, f_centi, f_num, f_div;

	bcc_front u_front (
		.clk, .arst_n, .en,
		.in_valid     (s_axis_tvalid),
		.temp_sample  (s_axis_tdata[19:0]),
		.press_sample (s_axis_tdata[39:20]),
		.cal,
		.out_valid    (f_vld),
		.fine_out     (f_fine),
		.centi_out    (f_centi),
		.num_out      (f_num),
		.div_out      (f_div),
		.shifted_out  (f_shifted)
	);

	localparam int unsigned TagW = 66;
	logic            d_vld;
	logic [31:0]     d_quo;
	logic [TagW-1:0] d_tag;

	bcc_divider #(.TagW(TagW)) u_div (
		.clk, .arst_n, .en,
		.in_valid  (f_vld),
		.dividend  (f_num),
		.divisor   (f_div),
		.in_tag    ({f_shifted, (f_div == '0), f_centi, f_fine}),
		.out_valid (d_vld),
		.quotient  (d_quo),
		.out_tag   (d_tag)
	);

	result_t res;
	bcc_back u_back (
		.clk, .arst_n, .en,
		.in_valid  (d_vld),
		.quotient  (d_quo),
		.shifted   (d_tag[65]),
		.zero_div  (d_tag[64]),
		.fine_in   (d_tag[31:0]),
		.centi_in  (d_tag[63:32]),
		.cal,
		.out_valid (m_axis_tvalid),
		.result    (res)
	);

	assign m_axis_tdata = {7'd0, res.pressure_invalid, res.pressure_pa,
		res.temperature_centi, res.fine_temperature};

	// zero divisor forces a zero pressure
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[96] |-> m_axis_tdata[95:64] == '0)
		else $error("invalid pressure not zero");
	// stalled output holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed under stall");
	// input ready follows output slot
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("ready mismatch");

endmodule
